// ===== sv/var_pkg.sv =====
// Package for the vector axis rotator: action codes, fixed-point constants
// and the CORDIC arctangent table. No dependencies.
package var_pkg;

  typedef enum logic [1:0] {
    ACT_ROT_X = 2'd0,
    ACT_ROT_Y = 2'd1,
    ACT_ROT_Z = 2'd2,
    ACT_NEW_Z = 2'd3
  } act_t;

  localparam logic signed [31:0] ONE_Q30  = 32'sd1073741824;
  localparam logic signed [31:0] HALF_Q30 = 32'sd536870912;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [31:0] SAT_MAX  = 32'sh7FFFFFFF;
  localparam logic signed [31:0] SAT_MIN  = 32'sh80000000;

  function automatic logic signed [31:0] atan_of(input logic [4:0] i);
    logic signed [31:0] a;
    case (i)
      5'd0:  a = 32'sd536870912;
      5'd1:  a = 32'sd316933406;
      5'd2:  a = 32'sd167458907;
      5'd3:  a = 32'sd85004756;
      5'd4:  a = 32'sd42667331;
      5'd5:  a = 32'sd21354465;
      5'd6:  a = 32'sd10680094;
      5'd7:  a = 32'sd5340245;
      5'd8:  a = 32'sd2670163;
      5'd9:  a = 32'sd1335087;
      5'd10: a = 32'sd667544;
      5'd11: a = 32'sd333772;
      5'd12: a = 32'sd166886;
      5'd13: a = 32'sd83443;
      5'd14: a = 32'sd41721;
      5'd15: a = 32'sd20860;
      5'd16: a = 32'sd10430;
      5'd17: a = 32'sd5215;
      5'd18: a = 32'sd2607;
      5'd19: a = 32'sd1303;
      5'd20: a = 32'sd651;
      5'd21: a = 32'sd325;
      5'd22: a = 32'sd162;
      5'd23: a = 32'sd81;
      5'd24: a = 32'sd40;
      5'd25: a = 32'sd20;
      5'd26: a = 32'sd10;
      5'd27: a = 32'sd5;
      5'd28: a = 32'sd2;
      5'd29: a = 32'sd1;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

endpackage

// ===== sv/vector_axis_rotator.sv =====
// Vector axis rotator: fully pipelined rotation of a Q16.16 3D vector.
// Depends on var_pkg for action codes, constants and the arctangent table.
//
// Usage:
//   Input beat: in_tuser carries the action, in_tdata the vector, the binary
//   angle and the Q2.30 axis. Actions 0..2 turn the vector about X, Y or Z;
//   action 3 carries it into the frame whose z axis is the given unit vector.
//   Output beat: out_tdata carries the rotated, saturated vector.
// Pipeline: the 32-stage square root and the 32-stage quotient pipeline lie in
//   series on the path to out_tvalid; the 32-stage CORDIC runs beside them. The
//   root and quotient stages retire one bit per stage, the first CORDIC_STEPS
//   CORDIC stages one iteration each.
// Throughput: one beat per cycle while the output is not stalled; every stage is registered.
// Reset: rst_n clears only the stage valid bits; the pipeline comes up empty.
// Stall: while out_tvalid is high and out_tready low, every stage holds and
//   in_tready is low; nothing is dropped or repeated.
module vector_axis_rotator
  import var_pkg::*;
#(
  parameter int CORDIC_STEPS = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // action
  input  logic [1:0]   in_tuser,
  // vec_x, vec_y, vec_z, turn_angle, axis_u1, axis_u2, axis_u3
  input  logic [223:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_x, out_y, out_z
  output logic [95:0]  out_tdata
);

  localparam int LAST = 72;

  function automatic logic signed [31:0] clamp_unit(input logic signed [31:0] v);
    if (v > ONE_Q30) return ONE_Q30;
    if (v < -ONE_Q30) return -ONE_Q30;
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'(SAT_MAX)) return SAT_MAX;
    if (v < 68'(SAT_MIN)) return SAT_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
    if (v == SAT_MIN) return SAT_MAX;
    return -v;
  endfunction

  function automatic logic signed [31:0] div_sat(input logic [31:0] q, input logic ovf,
                                                 input logic neg);
    if (!neg) begin
      if (ovf || q[31]) return SAT_MAX;
      return $signed(q);
    end
    if (ovf || (q > 32'h80000000)) return SAT_MIN;
    return -$signed(q);
  endfunction

  logic             en;
  logic [LAST:0]    v_r;

  act_t               act_d [0:LAST];
  logic signed [31:0] px_d [0:LAST];
  logic signed [31:0] py_d [0:LAST];
  logic signed [31:0] pz_d [0:LAST];
  logic signed [31:0] u1_d [0:LAST];
  logic signed [31:0] u2_d [0:LAST];
  logic signed [31:0] u3_d [0:LAST];
  logic [31:0]        up_d [35:LAST];

  logic signed [31:0] ang;
  logic               flip_nxt;
  logic signed [31:0] t_nxt;

  logic signed [33:0] cx_r [0:32];
  logic signed [33:0] cy_r [0:32];
  logic signed [33:0] ct_r [0:32];
  logic               flip_d [0:32];
  logic signed [33:0] sn_d [33:70];
  logic signed [33:0] cs_d [33:70];

  logic signed [63:0] uu1_r, uu2_r;
  logic [63:0]        up2_r;
  logic [63:0]        sq_v [0:31];
  logic [63:0]        sq_r [0:31];

  logic signed [63:0] pa13_r, pa23_r, pa33_r;
  logic signed [64:0] pb1_r, pb2_r, pb3_r;
  logic signed [31:0] a13_r, a23_r, a33_r;
  logic signed [32:0] b1_r, b2_r, b3_r;
  logic signed [64:0] tm_r [0:7];
  logic signed [66:0] n_r [0:2];

  logic [63:0]        rm_r  [39:71][0:2];
  logic [31:0]        q_r   [39:71][0:2];
  logic               ovf_r [39:71][0:2];
  logic               neg_r [39:71][0:2];

  logic signed [31:0] ra, rb;
  logic signed [65:0] mca_r, msb_r, msa_r, mcb_r;
  logic signed [67:0] f1, f2;
  logic signed [31:0] r1, r2;
  logic signed [31:0] ox_nxt, oy_nxt, oz_nxt;
  logic signed [31:0] ox_r, oy_r, oz_r;

  assign en         = !v_r[LAST] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = v_r[LAST];
  assign out_tdata  = {oz_r, oy_r, ox_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAST-1:0], in_tvalid};
    end
  end

  // Stage 0: capture, clamp the axis, fold the angle into +/- pi/2
  assign ang      = in_tdata[127:96];
  assign flip_nxt = (ang > ONE_Q30) || (ang < -ONE_Q30);
  assign t_nxt    = flip_nxt ? {~ang[31], ang[30:0]} : ang;

  always_ff @(posedge clk) begin
    if (en) begin
      act_d[0]  <= act_t'(in_tuser);
      px_d[0]   <= in_tdata[31:0];
      py_d[0]   <= in_tdata[63:32];
      pz_d[0]   <= in_tdata[95:64];
      u1_d[0]   <= clamp_unit(in_tdata[159:128]);
      u2_d[0]   <= clamp_unit(in_tdata[191:160]);
      u3_d[0]   <= clamp_unit(in_tdata[223:192]);
      cx_r[0]   <= GAIN_Q30;
      cy_r[0]   <= '0;
      ct_r[0]   <= 34'(t_nxt);
      flip_d[0] <= flip_nxt;
      for (int k = 1; k <= LAST; k++) begin
        act_d[k] <= act_d[k-1];
        px_d[k]  <= px_d[k-1];
        py_d[k]  <= py_d[k-1];
        pz_d[k]  <= pz_d[k-1];
        u1_d[k]  <= u1_d[k-1];
        u2_d[k]  <= u2_d[k-1];
        u3_d[k]  <= u3_d[k-1];
      end
      for (int k = 1; k <= 32; k++) begin
        flip_d[k] <= flip_d[k-1];
      end
      up_d[35] <= sq_r[31][31:0];
      for (int k = 36; k <= LAST; k++) begin
        up_d[k] <= up_d[k-1];
      end
    end
  end

  // CORDIC: one iteration per stage for the first CORDIC_STEPS stages; later stages pass through
  for (genvar k = 1; k <= 32; k++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en) begin
        if (k - 1 < CORDIC_STEPS) begin
          if (!ct_r[k-1][33]) begin
            cx_r[k] <= cx_r[k-1] - (cy_r[k-1] >>> (k - 1));
            cy_r[k] <= cy_r[k-1] + (cx_r[k-1] >>> (k - 1));
            ct_r[k] <= ct_r[k-1] - 34'(atan_of(5'(k - 1)));
          end else begin
            cx_r[k] <= cx_r[k-1] + (cy_r[k-1] >>> (k - 1));
            cy_r[k] <= cy_r[k-1] - (cx_r[k-1] >>> (k - 1));
            ct_r[k] <= ct_r[k-1] + 34'(atan_of(5'(k - 1)));
          end
        end else begin
          cx_r[k] <= cx_r[k-1];
          cy_r[k] <= cy_r[k-1];
          ct_r[k] <= ct_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn_d[33] <= flip_d[32] ? -cy_r[32] : cy_r[32];
      cs_d[33] <= flip_d[32] ? -cx_r[32] : cx_r[32];
      for (int k = 34; k <= 70; k++) begin
        sn_d[k] <= sn_d[k-1];
        cs_d[k] <= cs_d[k-1];
      end
    end
  end

  // Axis length: squares, sum, then one root bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      uu1_r <= u1_d[0] * u1_d[0];
      uu2_r <= u2_d[0] * u2_d[0];
      up2_r <= 64'(uu1_r + uu2_r);
    end
  end

  for (genvar k = 0; k < 32; k++) begin : g_sqrt
    localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] vin, rin, trial;
    if (k == 0) begin : g_first
      assign vin = up2_r;
      assign rin = '0;
    end else begin : g_next
      assign vin = sq_v[k-1];
      assign rin = sq_r[k-1];
    end
    assign trial = rin + SQ_BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (vin >= trial) begin
          sq_v[k] <= vin - trial;
          sq_r[k] <= (rin >> 1) + SQ_BIT;
        end else begin
          sq_v[k] <= vin;
          sq_r[k] <= rin >> 1;
        end
      end
    end
  end

  // Matrix terms, rounded to Q2.30, then numerators in Q21.46
  always_ff @(posedge clk) begin
    if (en) begin
      pa13_r <= u1_d[34] * u3_d[34];
      pa23_r <= u2_d[34] * u3_d[34];
      pa33_r <= u3_d[34] * u3_d[34];
      pb1_r  <= 65'(u1_d[34]) * $signed({1'b0, sq_r[31][31:0]});
      pb2_r  <= 65'(u2_d[34]) * $signed({1'b0, sq_r[31][31:0]});
      pb3_r  <= 65'(u3_d[34]) * $signed({1'b0, sq_r[31][31:0]});

      a13_r <= 32'((pa13_r + 64'(HALF_Q30)) >>> 30);
      a23_r <= 32'((pa23_r + 64'(HALF_Q30)) >>> 30);
      a33_r <= 32'(((pa33_r + 64'(HALF_Q30)) >>> 30) - 64'(ONE_Q30));
      b1_r  <= 33'((pb1_r + 65'(HALF_Q30)) >>> 30);
      b2_r  <= 33'((pb2_r + 65'(HALF_Q30)) >>> 30);
      b3_r  <= 33'((pb3_r + 65'(HALF_Q30)) >>> 30);

      tm_r[0] <= 65'(a13_r) * 65'(px_d[36]);
      tm_r[1] <= 65'(u2_d[36]) * 65'(py_d[36]);
      tm_r[2] <= 65'(b1_r) * 65'(pz_d[36]);
      tm_r[3] <= 65'(a23_r) * 65'(px_d[36]);
      tm_r[4] <= 65'(u1_d[36]) * 65'(py_d[36]);
      tm_r[5] <= 65'(b2_r) * 65'(pz_d[36]);
      tm_r[6] <= 65'(a33_r) * 65'(px_d[36]);
      tm_r[7] <= 65'(b3_r) * 65'(pz_d[36]);

      n_r[0] <= 67'(tm_r[0]) - 67'(tm_r[1]) + 67'(tm_r[2]);
      n_r[1] <= 67'(tm_r[3]) + 67'(tm_r[4]) + 67'(tm_r[5]);
      n_r[2] <= 67'(tm_r[6]) + 67'(tm_r[7]);
    end
  end

  // Rounded magnitude and quotient overflow check
  always_ff @(posedge clk) begin
    logic [66:0] mag;
    logic [63:0] mp;
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        mag = n_r[l][66] ? 67'(-n_r[l]) : 67'(n_r[l]);
        mp  = mag[63:0] + 64'(up_d[38] >> 1);
        rm_r[39][l]  <= mp;
        q_r[39][l]   <= '0;
        neg_r[39][l] <= n_r[l][66];
        ovf_r[39][l] <= mp >= {up_d[38], 32'b0};
      end
    end
  end

  // Restoring division: one quotient bit per stage
  for (genvar j = 0; j < 32; j++) begin : g_div
    logic [63:0] dsh;
    assign dsh = 64'(up_d[39+j]) << (31 - j);
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          neg_r[40+j][l] <= neg_r[39+j][l];
          ovf_r[40+j][l] <= ovf_r[39+j][l];
          if (rm_r[39+j][l] >= dsh) begin
            rm_r[40+j][l] <= rm_r[39+j][l] - dsh;
            q_r[40+j][l]  <= q_r[39+j][l] | (32'd1 << (31 - j));
          end else begin
            rm_r[40+j][l] <= rm_r[39+j][l];
            q_r[40+j][l]  <= q_r[39+j][l];
          end
        end
      end
    end
  end

  // Angle rotation products
  always_comb begin
    case (act_d[70])
      ACT_ROT_X: begin
        ra = py_d[70];
        rb = pz_d[70];
      end
      ACT_ROT_Y: begin
        ra = pz_d[70];
        rb = px_d[70];
      end
      default: begin
        ra = px_d[70];
        rb = py_d[70];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mca_r <= 66'(cs_d[70]) * 66'(ra);
      msb_r <= 66'(sn_d[70]) * 66'(rb);
      msa_r <= 66'(sn_d[70]) * 66'(ra);
      mcb_r <= 66'(cs_d[70]) * 66'(rb);
    end
  end

  // Output stage: round, saturate and select per action
  assign f1 = 68'(mca_r) - 68'(msb_r);
  assign f2 = 68'(msa_r) + 68'(mcb_r);
  assign r1 = sat32((f1 + 68'(HALF_Q30)) >>> 30);
  assign r2 = sat32((f2 + 68'(HALF_Q30)) >>> 30);

  always_comb begin
    ox_nxt = px_d[71];
    oy_nxt = py_d[71];
    oz_nxt = pz_d[71];
    case (act_d[71])
      ACT_ROT_X: begin
        oy_nxt = r1;
        oz_nxt = r2;
      end
      ACT_ROT_Y: begin
        oz_nxt = r1;
        ox_nxt = r2;
      end
      ACT_ROT_Z: begin
        ox_nxt = r1;
        oy_nxt = r2;
      end
      ACT_NEW_Z: begin
        if (up_d[71] != '0) begin
          ox_nxt = div_sat(q_r[71][0], ovf_r[71][0], neg_r[71][0]);
          oy_nxt = div_sat(q_r[71][1], ovf_r[71][1], neg_r[71][1]);
          oz_nxt = div_sat(q_r[71][2], ovf_r[71][2], neg_r[71][2]);
        end else if (u3_d[71][31]) begin
          ox_nxt = neg_sat(px_d[71]);
          oz_nxt = neg_sat(pz_d[71]);
        end
      end
      default: begin
        ox_nxt = px_d[71];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
      oz_r <= oz_nxt;
    end
  end

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    en && v_r[LAST-1] |=> out_tvalid)
    else $error("valid beat lost at output stage");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !en |=> $stable(v_r))
    else $error("pipeline moved during stall");

  a_root: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[34] |-> sq_r[31] < 64'd1518500250)
    else $error("axis length out of range");

endmodule

// ===== verif/vector_axis_rotator_chk.sv =====
`timescale 1ns / 1ps
// Checker for the vector axis rotator: watches both stream channels, predicts
// each rotated vector and compares it with the output beat. Uses var_pkg.
module vector_axis_rotator_chk
  import var_pkg::*;
#(
  parameter int CORDIC_STEPS = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [1:0]   in_tuser,
  input  logic [223:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [95:0]  out_tdata,
  output int           fail_cnt,
  output int           pending_cnt,
  output int           vec_cnt
);

  typedef logic signed [127:0] wide_t;

  logic [95:0] rotated_q[$];

  function automatic wide_t floor_shr(wide_t v, int s);
    return v >>> s;
  endfunction

  function automatic wide_t clip32(wide_t v);
    if (v > 128'sd2147483647) return 128'sd2147483647;
    if (v < -128'sd2147483648) return -128'sd2147483648;
    return v;
  endfunction

  function automatic wide_t clip_unit(wide_t v);
    if (v > 128'sd1073741824) return 128'sd1073741824;
    if (v < -128'sd1073741824) return -128'sd1073741824;
    return v;
  endfunction

  function automatic wide_t round_q30(wide_t a, wide_t b);
    return floor_shr(a * b + 128'sd536870912, 30);
  endfunction

  function automatic void sin_cos(logic [31:0] ang, output wide_t sn, output wide_t cs);
    wide_t t, x, y, nx;
    bit flip;
    t = wide_t'(signed'(ang));
    flip = 0;
    if (t > 128'sd1073741824 || t < -128'sd1073741824) begin
      t = wide_t'(signed'(ang ^ 32'h80000000));
      flip = 1;
    end
    x = 128'sd652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      if (t >= 0) begin
        nx = x - floor_shr(y, i);
        y = y + floor_shr(x, i);
        t = t - wide_t'(atan_of(i[4:0]));
      end else begin
        nx = x + floor_shr(y, i);
        y = y - floor_shr(x, i);
        t = t + wide_t'(atan_of(i[4:0]));
      end
      x = nx;
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic wide_t blend(wide_t p, wide_t q, wide_t r, wide_t w);
    return clip32(floor_shr(p * q + r * w + 128'sd536870912, 30));
  endfunction

  function automatic wide_t isqrt(wide_t v);
    wide_t r, b;
    r = 0;
    b = wide_t'(1) << 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic wide_t div_round(wide_t n, wide_t d);
    wide_t m, q;
    m = n < 0 ? -n : n;
    q = (m + d / 2) / d;
    return clip32(n < 0 ? -q : q);
  endfunction

  function automatic logic [95:0] rotate_vec(act_t act, logic [223:0] d);
    wide_t px, py, pz, rx, ry, rz, sn, cs, u1, u2, u3, up2, up;
    wide_t a13, a23, a33, b1, b2, b3;
    px = wide_t'(signed'(d[31:0]));
    py = wide_t'(signed'(d[63:32]));
    pz = wide_t'(signed'(d[95:64]));
    rx = px; ry = py; rz = pz;
    if (act != ACT_NEW_Z) begin
      sin_cos(d[127:96], sn, cs);
      case (act)
        ACT_ROT_X: begin
          ry = blend(cs, py, -sn, pz);
          rz = blend(sn, py, cs, pz);
        end
        ACT_ROT_Y: begin
          rz = blend(cs, pz, -sn, px);
          rx = blend(sn, pz, cs, px);
        end
        default: begin
          rx = blend(cs, px, -sn, py);
          ry = blend(sn, px, cs, py);
        end
      endcase
    end else begin
      u1 = clip_unit(wide_t'(signed'(d[159:128])));
      u2 = clip_unit(wide_t'(signed'(d[191:160])));
      u3 = clip_unit(wide_t'(signed'(d[223:192])));
      up2 = u1 * u1 + u2 * u2;
      if (up2 != 0) begin
        up = isqrt(up2);
        a13 = round_q30(u1, u3);
        a23 = round_q30(u2, u3);
        a33 = round_q30(u3, u3) - 128'sd1073741824;
        b1 = round_q30(u1, up);
        b2 = round_q30(u2, up);
        b3 = round_q30(u3, up);
        rx = div_round(a13 * px - u2 * py + b1 * pz, up);
        ry = div_round(a23 * px + u1 * py + b2 * pz, up);
        rz = div_round(a33 * px + b3 * pz, up);
      end else if (u3 < 0) begin
        rx = clip32(-px);
        rz = clip32(-pz);
      end
    end
    return {rz[31:0], ry[31:0], rx[31:0]};
  endfunction

  assign pending_cnt = rotated_q.size();

  always @(posedge clk) begin
    logic [95:0] want;
    int          nfail;
    nfail = 0;
    if (!rst_n) begin
      fail_cnt <= 0;
      vec_cnt <= 0;
    end else begin
      if (in_tvalid && in_tready) rotated_q.push_back(rotate_vec(act_t'(in_tuser), in_tdata));
      if (out_tvalid && out_tready) begin
        vec_cnt <= vec_cnt + 1;
        if (rotated_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %h", $time, out_tdata);
          nfail++;
        end else begin
          want = rotated_q.pop_front();
          for (int f = 0; f < 3; f++)
            if (want[f*32 +: 32] !== out_tdata[f*32 +: 32]) begin
              $display("%0t: field %0d mismatch, expected %h, actual %h",
                       $time, f, want[f*32 +: 32], out_tdata[f*32 +: 32]);
              nfail++;
            end
        end
      end
      fail_cnt <= fail_cnt + nfail;
    end
  end

endmodule

// ===== verif/vector_axis_rotator_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the vector axis rotator: clock, reset, stream stimulus
// and verdict. Depends on var_pkg, vector_axis_rotator and the checker.
module vector_axis_rotator_tb;
  import var_pkg::*;

  localparam int N_RANDOM   = 1700;
  localparam int IDLE_LIMIT = 5000;
  localparam int LATENCY    = 73;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [1:0]   in_tuser;
  logic [223:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;
  int           fail_cnt, pending_cnt, vec_cnt;
  int           sent_cnt;
  bit           calm;
  bit           hold_off;
  int           quiet_cycles;

  vector_axis_rotator i_dut (.*);

  vector_axis_rotator_chk i_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'h0 : 32'h00010000;
      3: return $urandom();
      default: return 32'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
    endcase
  endfunction

  function automatic logic [31:0] pick_unit();
    case ($urandom_range(0, 7))
      0: return ONE_Q30;
      1: return -ONE_Q30;
      2: return 32'h0;
      3: return $urandom();
      4: return 32'($urandom_range(0, 3));
      default: return 32'($signed($urandom_range(0, 32'h80000000)) - ONE_Q30);
    endcase
  endfunction

  task automatic send(act_t act, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                      logic [31:0] ang, logic [31:0] u1, logic [31:0] u2,
                      logic [31:0] u3);
    while (!calm && $urandom_range(0, 99) < 26) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {u3, u2, u1, ang, z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_cnt++;
    @(negedge clk);
  endtask

  task automatic send_random();
    act_t act;
    logic [31:0] u1, u2, u3;
    act = act_t'($urandom_range(0, 3));
    u1 = pick_unit();
    u2 = pick_unit();
    u3 = pick_unit();
    if ($urandom_range(0, 9) == 0) begin
      u1 = 0;
      u2 = 0;
    end
    send(act, pick_coord(), pick_coord(), pick_coord(), $urandom(), u1, u2, u3);
  endtask

  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= !hold_off && (calm || $urandom_range(0, 99) >= 26);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    hold_off = 0;
    repeat (200) @(negedge clk);
    hold_off = 1;
    repeat (300) @(negedge clk);
    hold_off = 0;
  end

  initial begin
    logic [31:0] ang_set[8];
    rst_n = 0;
    in_tvalid = 0;
    in_tuser = '0;
    in_tdata = '0;
    calm = 0;
    sent_cnt = 0;
    repeat (5) @(negedge clk);
    rst_n = 1;
    ang_set = '{32'h0, 32'h40000000, 32'hC0000000, 32'h40000001, 32'h80000000,
                32'h7FFFFFFF, 32'h20000000, 32'hBFFFFFFF};
    for (int a = 0; a < 3; a++)
      for (int k = 0; k < 4; k++)
        send(act_t'(a), 32'h7FFFFFFF, 32'h80000000, 32'h00018000,
             ang_set[a * 2 + k], 0, 0, 0);
    send(ACT_NEW_Z, 32'h80000000, 32'h12345678, 32'h80000000, 0, 0, 0, -ONE_Q30);
    send(ACT_NEW_Z, 32'h00010000, 32'h00020000, 32'h00030000, 0, 0, 0, ONE_Q30);
    send(ACT_NEW_Z, 32'h00010000, 32'h00020000, 32'h00030000, 0, 0, 0, 0);
    send(ACT_NEW_Z, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 1, 0, ONE_Q30);
    send(ACT_NEW_Z, 32'h00010000, 32'hFFFF0000, 32'h00050000, 0,
         32'h2D413CCD, 32'h2D413CCD, 0);
    send(ACT_NEW_Z, 32'h00010000, 32'h00010000, 32'h00010000, 0,
         32'h7FFFFFFF, 32'h80000000, 32'hC0000001);
    send(ACT_NEW_Z, 32'h00020000, 32'h00030000, 32'h00040000, 0,
         32'h10000000, 32'h20000000, 32'h30000000);
    send(ACT_NEW_Z, 32'hFFFFFFFF, 32'hAAAAAAAA, 32'h55555555, 0,
         32'hFFFFFFFF, 32'h0, 32'h0);
    for (int n = 0; n < N_RANDOM; n++) begin
      calm = (n >= 800 && n < 1000);
      send_random();
    end
    in_tvalid <= 1'b0;
    while (pending_cnt != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    $display("covered %0d vectors over all four actions, including saturation,", sent_cnt);
    $display("degenerate axes and a long output stall; %0d results checked", vec_cnt);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
